// File: rtl/etp_pkg.sv
`timescale 1ns / 1ps

package etp_pkg;

    localparam int OUT_W  = 48;
    localparam int TILE_W = 6;
    localparam int EX_W   = 2;
    localparam int COST_W = 32;

    typedef enum logic [0:0] {
        OP_PLACE = 1'b0,
        OP_CHECK = 1'b1
    } t_op;

    typedef enum logic [EX_W-1:0] {
        EX_DMA   = 2'd0,
        EX_DPU   = 2'd1,
        EX_SHAVE = 2'd2
    } t_exec;

endpackage

// File: rtl/etp_ram.sv
`timescale 1ns / 1ps

module etp_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/executor_timeline_placer.sv
`timescale 1ns / 1ps
// The tile-end RAM read lands with the stage 1 input register, and one pass of logic
// fills the result register when stage 1 advances.
// Throughput: one item per cycle while the result side keeps taking transfers.
// The rate is set by the single tile-end RAM read port plus a write-to-read bypass.
// Reset (sync, active low) clears all control and timeline state, then a clearing
// pass zeroes every tile-end RAM entry; o_in_ready stays low during it.
module executor_timeline_placer #(
    parameter int NUM_TILES  = 64,
    parameter int TIME_WIDTH = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic [etp_pkg::EX_W-1:0]      i_executor,
    input  logic [etp_pkg::TILE_W-1:0]    i_tile_index,
    input  logic [etp_pkg::COST_W-1:0]    i_cost,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_accepted,
    output logic                          o_became_last,
    output logic [etp_pkg::OUT_W-1:0]     o_start_time,
    output logic [etp_pkg::OUT_W-1:0]     o_end_time,
    output logic [etp_pkg::OUT_W-1:0]     o_total_end,
    output logic                          o_last_valid,
    output logic [etp_pkg::TILE_W-1:0]    o_last_tile,
    output logic [etp_pkg::OUT_W-1:0]     o_prefetch_slack
);

    import etp_pkg::*;

    localparam int AW       = $clog2(NUM_TILES);
    localparam int TW       = TIME_WIDTH;
    localparam int NUM_EXEC = 3;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

    // ------------------------------------------------------------------
    // Control: clearing pass, then run
    // ------------------------------------------------------------------
    t_state        r_state;
    logic [AW-1:0] r_clr_cnt;
    logic          clearing;

    assign clearing = (r_state == ST_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + AW'(1);
                    if (r_clr_cnt == AW'(NUM_TILES - 1)) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_state <= ST_RUN;
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake
    // Stage 1 holds the accepted item while the RAM read lands; it moves
    // into the result register when that register is free or drained.
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic advance;
    logic in_xfer;

    assign advance    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !clearing && (!r_s1_valid || advance);
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage 1 payload
    logic              r_s1_op;
    logic [EX_W-1:0]   r_s1_ex;
    logic [TILE_W-1:0] r_s1_tile;
    logic [COST_W-1:0] r_s1_cost;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_op   <= i_op;
            r_s1_ex   <= i_executor;
            r_s1_tile <= i_tile_index;
            r_s1_cost <= i_cost;
        end
    end

    // ------------------------------------------------------------------
    // Tile-end RAM: {seen, end} per tile
    // ------------------------------------------------------------------
    logic [AW+TILE_W-1:0] rd_addr_wide;
    logic [AW+TILE_W-1:0] s1_addr_wide;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        s1_addr;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [TW:0]          ram_wdata;
    logic [TW:0]          ram_rdata;

    assign rd_addr_wide = {AW'(0), i_tile_index};
    assign s1_addr_wide = {AW'(0), r_s1_tile};
    assign rd_addr      = rd_addr_wide[AW-1:0];
    assign s1_addr      = s1_addr_wide[AW-1:0];

    logic          place_ok;
    logic [TW-1:0] end_t;

    assign ram_we    = clearing || (advance && place_ok);
    assign ram_waddr = clearing ? r_clr_cnt : s1_addr;
    assign ram_wdata = clearing ? '0 : {1'b1, end_t};

    etp_ram #(
        .WIDTH (TW + 1),
        .DEPTH (NUM_TILES)
    ) u_tile_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_xfer),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // bypass: the item leaving stage 1 writes the tile the new item reads
    logic        r_byp_hit;
    logic [TW:0] r_byp_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else if (in_xfer) begin
            r_byp_hit <= advance && place_ok && (s1_addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_byp_data <= {1'b1, end_t};
        end
    end

    // ------------------------------------------------------------------
    // Timeline state
    // ------------------------------------------------------------------
    logic              r_nonempty;
    logic [TW-1:0]     r_last_end;
    logic [TILE_W-1:0] r_last_tile;
    logic [EX_W-1:0]   r_last_ex;
    logic [TW-1:0]     r_ex_end  [NUM_EXEC];
    logic              r_ex_seen [NUM_EXEC];

    // ------------------------------------------------------------------
    // Stage 1 compute
    // ------------------------------------------------------------------
    logic          ex_ok;
    logic          tile_ok;
    logic [TW-1:0] ex_end_sel;
    logic          ex_seen_sel;
    logic [TW:0]   tile_rd;
    logic          t_seen;
    logic [TW-1:0] t_end;

    assign ex_ok   = (r_s1_ex == EX_DMA) || (r_s1_ex == EX_DPU) || (r_s1_ex == EX_SHAVE);
    assign tile_ok = 32'(r_s1_tile) < 32'(NUM_TILES);
    assign tile_rd = r_byp_hit ? r_byp_data : ram_rdata;
    assign t_seen  = tile_rd[TW];
    assign t_end   = tile_rd[TW-1:0];

    always_comb begin
        ex_end_sel  = '0;
        ex_seen_sel = 1'b0;
        unique case (r_s1_ex)
            EX_DMA: begin
                ex_end_sel  = r_ex_end[0];
                ex_seen_sel = r_ex_seen[0];
            end
            EX_DPU: begin
                ex_end_sel  = r_ex_end[1];
                ex_seen_sel = r_ex_seen[1];
            end
            EX_SHAVE: begin
                ex_end_sel  = r_ex_end[2];
                ex_seen_sel = r_ex_seen[2];
            end
            default: begin
                ex_end_sel  = '0;
                ex_seen_sel = 1'b0;
            end
        endcase
    end

    // place: pick the start, then saturating add
    logic          place_cand;
    logic          force_last;
    logic [TW-1:0] start_t;
    logic [TW:0]   sum_t;
    logic          became_last;

    assign place_cand = (r_s1_op == OP_PLACE) && (r_s1_cost != '0) && ex_ok && tile_ok;

    always_comb begin
        place_ok   = 1'b0;
        force_last = 1'b0;
        start_t    = '0;
        priority if (!place_cand) begin
            place_ok = 1'b0;
        end else if (!r_nonempty) begin
            place_ok   = 1'b1;
            force_last = 1'b1;
        end else if (r_s1_tile == r_last_tile) begin
            place_ok   = 1'b1;
            force_last = 1'b1;
            start_t    = r_last_end;
        end else if (ex_seen_sel || t_seen) begin
            // unseen entries hold zero, so a plain max is enough
            place_ok = 1'b1;
            start_t  = (ex_end_sel > t_end) ? ex_end_sel : t_end;
        end else begin
            place_ok = 1'b0;
        end
    end

    assign sum_t       = {1'b0, start_t} + (TW+1)'(r_s1_cost);
    assign end_t       = sum_t[TW] ? '1 : sum_t[TW-1:0];
    assign became_last = place_ok && (force_last || (end_t >= r_last_end));

    // check: would executor end + cost fit under the current total end
    logic [TW:0] chk_sum;
    logic        chk_ok;

    assign chk_sum = {1'b0, ex_end_sel} + (TW+1)'(r_s1_cost);
    assign chk_ok  = (r_s1_op == OP_CHECK) && r_nonempty && ex_ok &&
                     (r_s1_tile != r_last_tile) && (r_s1_ex != r_last_ex) &&
                     ex_seen_sel && (chk_sum <= {1'b0, r_last_end});

    // next timeline state
    logic              n_nonempty;
    logic [TW-1:0]     n_last_end;
    logic [TILE_W-1:0] n_last_tile;
    logic [TW-1:0]     n_dma_end;

    assign n_nonempty  = became_last ? 1'b1 : r_nonempty;
    assign n_last_end  = became_last ? end_t : r_last_end;
    assign n_last_tile = became_last ? r_s1_tile : r_last_tile;
    assign n_dma_end   = (place_ok && (r_s1_ex == EX_DMA)) ? end_t : r_ex_end[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty  <= 1'b0;
            r_last_end  <= '0;
            r_last_tile <= '0;
            r_last_ex   <= '0;
            for (int i = 0; i < NUM_EXEC; i++) begin
                r_ex_end[i]  <= '0;
                r_ex_seen[i] <= 1'b0;
            end
        end else if (advance && place_ok) begin
            for (int i = 0; i < NUM_EXEC; i++) begin
                if (r_s1_ex == EX_W'(i)) begin
                    r_ex_end[i]  <= end_t;
                    r_ex_seen[i] <= 1'b1;
                end
            end
            if (became_last) begin
                r_nonempty  <= 1'b1;
                r_last_end  <= end_t;
                r_last_tile <= r_s1_tile;
                r_last_ex   <= r_s1_ex;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic              r_out_acc;
    logic              r_out_bl;
    logic [TW-1:0]     r_out_start;
    logic [TW-1:0]     r_out_end;
    logic [TW-1:0]     r_out_total;
    logic              r_out_lvalid;
    logic [TILE_W-1:0] r_out_ltile;
    logic [TW-1:0]     r_out_dma;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_acc    <= (r_s1_op == OP_CHECK) ? chk_ok : place_ok;
            r_out_bl     <= became_last;
            r_out_start  <= place_ok ? start_t : '0;
            r_out_end    <= place_ok ? end_t : '0;
            r_out_total  <= n_last_end;
            r_out_lvalid <= n_nonempty;
            r_out_ltile  <= n_last_tile;
            r_out_dma    <= n_dma_end;
        end
    end

    // slack taken from the registered result; zero when empty since both ends are zero
    logic [TW-1:0] slack;
    assign slack = (r_out_total > r_out_dma) ? (r_out_total - r_out_dma) : '0;

    logic [OUT_W+TW-1:0] w_start;
    logic [OUT_W+TW-1:0] w_end;
    logic [OUT_W+TW-1:0] w_total;
    logic [OUT_W+TW-1:0] w_slack;

    assign w_start = {OUT_W'(0), r_out_start};
    assign w_end   = {OUT_W'(0), r_out_end};
    assign w_total = {OUT_W'(0), r_out_total};
    assign w_slack = {OUT_W'(0), slack};

    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_out_acc;
    assign o_became_last    = r_out_bl;
    assign o_start_time     = w_start[OUT_W-1:0];
    assign o_end_time       = w_end[OUT_W-1:0];
    assign o_total_end      = w_total[OUT_W-1:0];
    assign o_last_valid     = r_out_lvalid;
    assign o_last_tile      = r_out_ltile;
    assign o_prefetch_slack = w_slack[OUT_W-1:0];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_input_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_in_ready)
        else $error("input taken during RAM clearing pass");

    a_last_end_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |=> (r_last_end >= $past(r_last_end)))
        else $error("total end moved backward");

    a_last_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bl) |-> r_out_acc)
        else $error("became_last without accepted");

    a_end_not_before_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_end >= r_out_start))
        else $error("interval ends before it starts");

    a_bypass_only_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !(advance && place_ok)) |=> !r_byp_hit)
        else $error("bypass set without a RAM write");

endmodule
